### hw/rtl/bole_pkg.sv
// shared constants, codes and types of the bounded ordered list engine
`default_nettype none

package bole_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int CMD_W   = 3;
	localparam int HANDLE_W = 16;
	localparam int POS_W   = 8;
	localparam int KIND_W  = 3;
	localparam int ENTRY_W = 16;
	localparam int OCC_W   = 5;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PREPEND   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FIRST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_LAST  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd5;

	// classified operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
	localparam logic [OP_W-1:0] OP_PREPEND   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_LAST  = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd5;
	localparam logic [OP_W-1:0] OP_NONE      = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [HANDLE_W-1:0] handle;
		logic [POS_W-1:0]    position;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/bole_front.sv
// command decoder and two-entry command queue
`default_nettype none

module bole_front
	import bole_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	output logic                      cmd_valid,
	output cmd_t                      cmd,
	input  wire logic                 cmd_pop
);

	logic [CMD_W-1:0] command;
	cmd_t             dec;
	cmd_t             queue_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       level_q;
	logic             push;
	logic             pop;

	assign command = s_axis_tdata[CMD_W-1:0];

	always_comb begin
		dec.handle   = s_axis_tdata[CMD_W +: HANDLE_W];
		dec.position = s_axis_tdata[CMD_W+HANDLE_W +: POS_W];
		unique case (command)
			CMD_DUMP:      dec.op = OP_DUMP;
			CMD_APPEND:    dec.op = OP_APPEND;
			CMD_PREPEND:   dec.op = OP_PREPEND;
			CMD_POP_FIRST: dec.op = OP_POP_FIRST;
			CMD_POP_LAST:  dec.op = OP_POP_LAST;
			CMD_REMOVE_AT: dec.op = OP_REMOVE_AT;
			default:       dec.op = OP_NONE;
		endcase
	end

	assign s_axis_tready = level_q != 2'd2;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = level_q != 2'd0;
	assign pop           = cmd_pop && cmd_valid;
	assign cmd           = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bole_back.sv
// shifting list cells, command sequencer and output register
`default_nettype none

module bole_back
	import bole_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire cmd_t                  cmd,
	output logic                       cmd_pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [KIND_W-1:0]          m_axis_tuser,
	output logic                       m_axis_tlast
);

	localparam int CELL_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	localparam logic [2:0] ACT_HOLD    = 3'd0;
	localparam logic [2:0] ACT_APPEND  = 3'd1;
	localparam logic [2:0] ACT_PREPEND = 3'd2;
	localparam logic [2:0] ACT_SHIFT   = 3'd3;
	localparam logic [2:0] ACT_ROTATE  = 3'd4;

	logic [CELL_W-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  rem_d;
	logic              state_q;
	logic              state_d;
	logic [2:0]        act;
	logic [CMP_W-1:0]  lo_idx;
	logic [CMP_W-1:0]  pos_x;
	logic [CELL_W-1:0] new_cell;
	logic [DEPTH-1:0]  any_vec;
	logic [DEPTH-1:0]  more_vec;
	logic              can_load;
	logic              load;
	logic [KIND_W-1:0] kind_d;
	logic [ENTRY_W-1:0] entry_d;
	logic              last_d;
	logic              full;

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [ENTRY_W-1:0] entry_q;
	logic              last_q;
	logic [OCC_W-1:0]  occ_q;

	assign new_cell = CELL_W'(cmd.handle);
	assign full     = count_q == CNT_W'(DEPTH);
	assign pos_x    = CMP_W'(cmd.position);
	assign can_load = !out_valid_q || m_axis_tready;

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			any_vec[j]  = (cell_q[j] != '0) && (CNT_W'(j) < count_q);
			more_vec[j] = (cell_q[j] != '0) && (j >= 1) && (CNT_W'(j) < rem_q);
		end
	end

	always_comb begin
		act     = ACT_HOLD;
		lo_idx  = '0;
		load    = 1'b0;
		kind_d  = KIND_DONE;
		entry_d = '0;
		last_d  = 1'b1;
		count_d = count_q;
		rem_d   = rem_q;
		state_d = state_q;
		cmd_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && can_load) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					unique case (cmd.op)
						OP_DUMP: begin
							if (|any_vec) begin
								cmd_pop = 1'b0;
								load    = 1'b0;
								state_d = ST_DUMP;
								rem_d   = count_q;
							end else begin
								kind_d = KIND_EMPTY;
							end
						end
						OP_APPEND: begin
							if (full) begin
								kind_d = KIND_FULL;
							end else begin
								act     = ACT_APPEND;
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_PREPEND: begin
							if (full) begin
								kind_d = KIND_FULL;
							end else begin
								act     = ACT_PREPEND;
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_POP_FIRST: begin
							if (count_q != '0) begin
								act     = ACT_SHIFT;
								count_d = count_q - CNT_W'(1);
							end else begin
								kind_d = KIND_IGNORED;
							end
						end
						OP_POP_LAST: begin
							if (count_q != '0) begin
								count_d = count_q - CNT_W'(1);
							end else begin
								kind_d = KIND_IGNORED;
							end
						end
						OP_REMOVE_AT: begin
							if (pos_x != '0 && pos_x <= CMP_W'(count_q)) begin
								act     = ACT_SHIFT;
								lo_idx  = pos_x - CMP_W'(1);
								count_d = count_q - CNT_W'(1);
							end else begin
								kind_d = KIND_IGNORED;
							end
						end
						default: kind_d = KIND_IGNORED;
					endcase
				end
			end
			ST_DUMP: begin
				if (can_load) begin
					act     = ACT_ROTATE;
					load    = cell_q[0] != '0;
					kind_d  = KIND_ENTRY;
					entry_d = ENTRY_W'(cell_q[0]);
					last_d  = !(|more_vec);
					rem_d   = rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
						cmd_pop = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			case (act)
				ACT_APPEND: begin
					if (CNT_W'(i) == count_q) begin
						cell_q[i] <= new_cell;
					end
				end
				ACT_PREPEND: begin
					cell_q[i] <= (i == 0) ? new_cell : cell_q[(i > 0) ? i - 1 : 0];
				end
				ACT_SHIFT: begin
					if (CMP_W'(i) >= lo_idx) begin
						cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
				ACT_ROTATE: begin
					if (CNT_W'(i) == count_q - CNT_W'(1)) begin
						cell_q[i] <= cell_q[0];
					end else begin
						cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
				default: cell_q[i] <= cell_q[i];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_d;
			entry_q <= entry_d;
			last_q  <= last_d;
			occ_q   <= OCC_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - ENTRY_W - OCC_W){1'b0}}, occ_q, entry_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list count above depth");

	a_dump_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP && $past(state_q) == ST_DUMP |-> $stable(count_q))
		else $error("list count changed during dump");

	a_dump_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> rem_q != '0 && rem_q <= count_q)
		else $error("dump remainder out of range");

	a_dump_no_pop_early: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP && rem_q != CNT_W'(1) |-> !cmd_pop)
		else $error("command released before dump finished");

endmodule

`default_nettype wire

### hw/rtl/bounded_ordered_list_engine_top.sv
// top level of the bounded ordered list engine
//
// channel   dir  tdata (low bit up)                  tuser   tlast
// s_axis    in   command[2:0] handle[18:3] pos[26:19]  -       -
// m_axis    out  entry[15:0] occupancy[20:16]          kind    last result of command
//
// edits act on the list cells once queued; a dump of a list that holds a non-zero entry
// rotates the cell row once per held entry, otherwise it returns an empty result
// the two-entry command queue lets input transactions land while the cells are busy
// the output register holds a result until taken; the cells stall only while it is full
// arst_n clears the count, queue and output valid; cell contents need no reset
`default_nettype none

module bounded_ordered_list_engine_top
	import bole_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // command, handle, position
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // entry, occupancy
	output logic [KIND_W-1:0]          m_axis_tuser,  // kind
	output logic                       m_axis_tlast
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	bole_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	bole_back #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
